// ===== hw/rtl/pal_pkg.sv =====
// Package for the positional array list unit.
// Holds list capacity, field widths, command/status codes and sequencer states.
// No dependencies.
package pal_pkg;

    localparam int CAPACITY = 128;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STS_W    = 3;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W >= POS_W) ? CNT_W + 1 : POS_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK          = 3'd0,
        STS_BAD_POS     = 3'd1,
        STS_NOT_CREATED = 3'd2,
        STS_FULL        = 3'd3,
        STS_NOT_FOUND   = 3'd4,
        STS_ALREADY     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TAIL,
        S_PUT,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/pal_if.sv =====
// Request and response channel interfaces for the positional array list unit.
// Depends on pal_pkg for field widths.
interface pal_req_if import pal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STS_W-1:0]        status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        element_count;

    modport source (output valid, status, found_position, read_value, element_count,
                    input ready);
    modport sink   (input valid, status, found_position, read_value, element_count,
                    output ready);
endinterface

// ===== hw/rtl/positional_array_list_unit.sv =====
// Positional array list unit: packed 1-based list in a single-port-write memory.
// Depends on pal_pkg and the pal_req_if / pal_rsp_if interfaces.
//
//   channel | dir | handshake            | payload
//   i_req   | in  | valid/ready          | command, position, value
//   o_rsp   | out | valid/ready          | status, found_position, read_value, element_count
//
// One request at a time; i_req.ready is high only while the sequencer is idle.
// Insert, delete and search walk the memory one entry per cycle through its one read
// port; a read fetches its one entry the same way.
// Create and rejected requests skip the walk.
// Synchronous active-low reset clears count, created flag and control; memory is not cleared.
// A pending response stalls the sequencer in its final state until o_rsp.ready.
module positional_array_list_unit import pal_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pal_req_if.sink   i_req,
    pal_rsp_if.source o_rsp
);

    logic [VAL_W-1:0]        r_mem [CAPACITY];
    logic [VAL_W-1:0]        r_rdata;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [ADDR_W-1:0]       r_idx, n_idx;
    logic [ADDR_W-1:0]       r_end, n_end;
    logic [ADDR_W-1:0]       r_put, n_put;
    logic [ADDR_W-1:0]       r_paddr, n_paddr;
    logic                    r_pend, n_pend;
    logic [VAL_W-1:0]        r_val, n_val;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_created, n_created;
    t_status                 r_status, n_status;
    logic [POS_W-1:0]        r_found, n_found;
    logic [VAL_W-1:0]        r_rd, n_rd;

    logic                    r_o_valid, n_o_valid;
    t_status                 r_o_status, n_o_status;
    logic [POS_W-1:0]        r_o_found, n_o_found;
    logic [VAL_W-1:0]        r_o_rd, n_o_rd;
    logic [POS_W-1:0]        r_o_count, n_o_count;

    logic                    accept;
    logic                    out_free;
    logic                    srch_hit;
    logic [CMP_W-1:0]        p_ext, c_ext;
    t_state                  dec_state;
    t_status                 dec_status;
    logic [ADDR_W-1:0]       dec_start, dec_end;
    logic [CNT_W-1:0]        dec_count;
    logic                    dec_created;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [VAL_W-1:0]        mem_wdata;
    logic                    mem_re;

    assign accept   = i_req.valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || o_rsp.ready;
    assign srch_hit = (r_state == S_WALK || r_state == S_TAIL) && r_pend
                      && (r_cmd == CMD_SEARCH) && (r_rdata == r_val);
    assign p_ext    = CMP_W'(i_req.position);
    assign c_ext    = CMP_W'(r_count);

    always_comb begin
        dec_state   = S_DONE;
        dec_status  = STS_OK;
        dec_start   = '0;
        dec_end     = '0;
        dec_count   = r_count;
        dec_created = r_created;
        if (t_cmd'(i_req.command) == CMD_CREATE) begin
            if (r_created) begin
                dec_status = STS_ALREADY;
            end else begin
                dec_created = 1'b1;
                dec_count   = '0;
            end
        end else if (!r_created) begin
            dec_status = STS_NOT_CREATED;
        end else begin
            case (t_cmd'(i_req.command))
                CMD_INSERT: begin
                    if (r_count == CNT_W'(CAPACITY)) begin
                        dec_status = STS_FULL;
                    end else if (p_ext == '0 || p_ext > c_ext + CMP_W'(1)) begin
                        dec_status = STS_BAD_POS;
                    end else begin
                        dec_count = r_count + CNT_W'(1);
                        dec_start = ADDR_W'(c_ext - CMP_W'(1));
                        dec_end   = ADDR_W'(p_ext - CMP_W'(1));
                        dec_state = (p_ext == c_ext + CMP_W'(1)) ? S_PUT : S_WALK;
                    end
                end
                CMD_DELETE: begin
                    if (p_ext == '0 || p_ext > c_ext) begin
                        dec_status = STS_BAD_POS;
                    end else begin
                        dec_count = r_count - CNT_W'(1);
                        dec_start = ADDR_W'(p_ext);
                        dec_end   = ADDR_W'(c_ext - CMP_W'(1));
                        dec_state = (p_ext == c_ext) ? S_DONE : S_WALK;
                    end
                end
                CMD_SEARCH: begin
                    dec_status = STS_NOT_FOUND;
                    dec_start  = '0;
                    dec_end    = ADDR_W'(c_ext - CMP_W'(1));
                    dec_state  = (r_count == '0) ? S_DONE : S_WALK;
                end
                CMD_READ: begin
                    if (p_ext == '0 || p_ext > c_ext) begin
                        dec_status = STS_BAD_POS;
                    end else begin
                        dec_start = ADDR_W'(p_ext - CMP_W'(1));
                        dec_end   = ADDR_W'(p_ext - CMP_W'(1));
                        dec_state = S_WALK;
                    end
                end
                default: begin
                    dec_status = STS_BAD_POS;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = dec_state;
            end
            S_WALK: begin
                if (srch_hit) begin
                    n_state = S_DONE;
                end else if (r_idx == r_end) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = (r_cmd == CMD_INSERT) ? S_PUT : S_DONE;
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_end      = r_end;
        n_put      = r_put;
        n_paddr    = r_paddr;
        n_pend     = r_pend;
        n_val      = r_val;
        n_count    = r_count;
        n_created  = r_created;
        n_status   = r_status;
        n_found    = r_found;
        n_rd       = r_rd;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_rd     = r_o_rd;
        n_o_count  = r_o_count;
        mem_we     = 1'b0;
        mem_waddr  = r_put;
        mem_wdata  = r_val;
        mem_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = t_cmd'(i_req.command);
                    n_val     = i_req.value;
                    n_put     = ADDR_W'(p_ext - CMP_W'(1));
                    n_idx     = dec_start;
                    n_end     = dec_end;
                    n_pend    = 1'b0;
                    n_count   = dec_count;
                    n_created = dec_created;
                    n_status  = dec_status;
                    n_found   = '0;
                    n_rd      = '0;
                end
            end
            S_WALK: begin
                mem_re  = 1'b1;
                n_pend  = 1'b1;
                n_paddr = r_idx;
                n_idx   = (r_cmd == CMD_INSERT) ? r_idx - ADDR_W'(1) : r_idx + ADDR_W'(1);
            end
            S_TAIL: begin
                n_pend = 1'b0;
            end
            S_PUT: begin
                mem_we = 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_found  = r_found;
                    n_o_rd     = r_rd;
                    n_o_count  = POS_W'(r_count);
                end
            end
            default: begin
            end
        endcase

        // retire the entry read in the previous cycle
        if ((r_state == S_WALK || r_state == S_TAIL) && r_pend) begin
            case (r_cmd)
                CMD_INSERT: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_paddr + ADDR_W'(1);
                    mem_wdata = r_rdata;
                end
                CMD_DELETE: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_paddr - ADDR_W'(1);
                    mem_wdata = r_rdata;
                end
                CMD_SEARCH: begin
                    if (srch_hit) begin
                        n_status = STS_OK;
                        n_found  = POS_W'({1'b0, r_paddr} + (ADDR_W + 1)'(1));
                        n_pend   = 1'b0;
                    end
                end
                CMD_READ: begin
                    n_rd = r_rdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_count   <= '0;
            r_created <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_count   <= n_count;
            r_created <= n_created;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_end      <= n_end;
        r_put      <= n_put;
        r_paddr    <= n_paddr;
        r_val      <= n_val;
        r_status   <= n_status;
        r_found    <= n_found;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_rd     <= n_o_rd;
        r_o_count  <= n_o_count;
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.found_position = r_o_found;
    assign o_rsp.read_value     = r_o_rd;
    assign o_rsp.element_count  = r_o_count;

endmodule

// ===== hw/rtl/pal_chk.sv =====
// Port-level checker for the positional array list unit, bound to the top level.
// Depends on pal_pkg and positional_array_list_unit.
module pal_chk import pal_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [STS_W-1:0] i_status,
    input logic [POS_W-1:0] i_found,
    input logic [VAL_W-1:0] i_rd,
    input logic [POS_W-1:0] i_count
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_found) && $stable(i_rd) && $stable(i_count))
        else $error("response changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_found != '0 |-> i_status == STS_OK)
        else $error("found position on failed request");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rd != '0 |-> i_status == STS_OK)
        else $error("read data on failed request");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (CAPACITY > 255) || (int'(i_count) <= CAPACITY))
        else $error("element count above capacity");

endmodule

bind positional_array_list_unit pal_chk u_pal_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_found     (o_rsp.found_position),
    .i_rd        (o_rsp.read_value),
    .i_count     (o_rsp.element_count)
);
